### rtl/skc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skc_pkg
// Shared constants, operation codes and microcode for the seed-to-key unit.
// ----------------------------------------------------------------------------
package skc_pkg;

   localparam int NUM_ALGOS    = 256;
   localparam int ENTRY_BYTES  = 13;
   localparam int OPS_PER_ALGO = 4;
   localparam int TABLE_DEPTH  = NUM_ALGOS * ENTRY_BYTES;
   localparam int ADDR_W       = $clog2(TABLE_DEPTH);
   localparam int OPCNT_W      = (OPS_PER_ALGO > 1) ? $clog2(OPS_PER_ALGO) : 1;

   localparam logic [7:0] OP_SWAP     = 8'h05;
   localparam logic [7:0] OP_ADD_HL   = 8'h14;
   localparam logic [7:0] OP_ADD_LH   = 8'h75;
   localparam logic [7:0] OP_SUB_HL   = 8'h98;
   localparam logic [7:0] OP_SUB_LH   = 8'hF8;
   localparam logic [7:0] OP_NOT_INC  = 8'h2A;
   localparam logic [7:0] OP_AND_LH   = 8'h37;
   localparam logic [7:0] OP_OR_LH    = 8'h52;
   localparam logic [7:0] OP_ROL      = 8'h4C;
   localparam logic [7:0] OP_ROR      = 8'h6B;
   localparam logic [7:0] OP_SWAP_ADD = 8'h7E;

   localparam int STEP_W = 3;

   localparam logic [STEP_W-1:0] STEP_RD_CODE = 3'd0;
   localparam logic [STEP_W-1:0] STEP_RD_HH   = 3'd1;
   localparam logic [STEP_W-1:0] STEP_RD_LL   = 3'd2;
   localparam logic [STEP_W-1:0] STEP_EXEC    = 3'd3;
   localparam logic [STEP_W-1:0] STEP_DONE    = 3'd4;

   typedef struct packed {
      logic mem_rd;
      logic ld_code;
      logic ld_hh;
      logic exec;
      logic jmp_more;
      logic done;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode(input logic [STEP_W-1:0] step);
      ctrl_word_type cw;
      cw = '0;
      unique case (step)
         STEP_RD_CODE: cw.mem_rd = 1'b1;
         STEP_RD_HH: begin
            cw.mem_rd  = 1'b1;
            cw.ld_code = 1'b1;
         end
         STEP_RD_LL: begin
            cw.mem_rd = 1'b1;
            cw.ld_hh  = 1'b1;
         end
         STEP_EXEC: begin
            cw.exec     = 1'b1;
            cw.jmp_more = 1'b1;
         end
         STEP_DONE: cw.done = 1'b1;
         default:   cw.done = 1'b1;
      endcase
      return cw;
   endfunction

   function automatic logic [15:0] rotl16(input logic [15:0] v, input logic [3:0] n);
      logic [31:0] w;
      w = {v, v} << n;
      return w[31:16];
   endfunction

   function automatic logic [15:0] apply_op(input logic [15:0] v, input logic [7:0] code,
                                            input logic [7:0] hh, input logic [7:0] ll);
      logic [15:0] hl;
      logic [15:0] lh;
      logic [15:0] r;
      hl = {hh, ll};
      lh = {ll, hh};
      case (code)
         OP_SWAP:     r = {v[7:0], v[15:8]};
         OP_ADD_HL:   r = v + hl;
         OP_ADD_LH:   r = v + lh;
         OP_SUB_HL:   r = v - hl;
         OP_SUB_LH:   r = v - lh;
         OP_NOT_INC:  r = ~v + {15'd0, (hh < ll)};
         OP_AND_LH:   r = v & lh;
         OP_OR_LH:    r = v | lh;
         OP_ROL:      r = rotl16(v, hh[3:0]);
         OP_ROR:      r = rotl16(v, 4'(5'd16 - {1'b0, ll[3:0]}));
         OP_SWAP_ADD: r = {v[7:0], v[15:8]} + ((hh >= ll) ? hl : lh);
         default:     r = v;
      endcase
      return r;
   endfunction

endpackage

### rtl/table_driven_seed_key_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_driven_seed_key_unit
// Seed-to-key transform run by a microcoded sequencer over a loadable table.
// ----------------------------------------------------------------------------
// Usage:
//   One request channel (req_*) carries either a table byte write
//   (req_mode = 0) or a key request (req_mode = 1, req_algo, req_seed).
//   The response channel (rsp_*) carries one key per key request.
//   A table write completes in the transfer cycle and yields no response.
//   A key request walks four (code, hh, ll) triples: four microcode steps
//   per triple, three reads from the byte RAM's single read port plus one
//   execute step, then a done step hands the key to the output register,
//   which raises rsp_valid. Algorithm 0 skips the table walk and goes
//   straight to the done step.
//   One key request is in flight at a time; req_stall is high while the
//   sequencer runs, so a key request can follow once the last key is handed
//   off; table writes can follow back to back. The output register holds a
//   finished key while rsp_stall is high, and a new request is taken
//   meanwhile; a second finished key then waits in the sequencer until the
//   register drains. Reset clears the sequencer and the output valid; table
//   contents are undefined until written and are not cleared.
// ----------------------------------------------------------------------------
module table_driven_seed_key_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [11:0] req_table_address,
   input  logic [7:0]  req_table_byte,
   input  logic [7:0]  req_algo,
   input  logic [15:0] req_seed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_key
);
   import skc_pkg::*;

   logic                busy_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [STEP_W-1:0]   step_in;
   logic [OPCNT_W-1:0]  opcnt_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [15:0]         value_ff;
   logic [7:0]          code_ff;
   logic [7:0]          hh_ff;
   logic                rsp_valid_ff;
   logic [15:0]         rsp_key_ff;
   logic [7:0]          rd_data;
   logic                req_xfer;
   logic                handoff;
   logic                op_last;
   ctrl_word_type       cw;

   assign req_stall = busy_ff;
   assign req_xfer  = req_valid && !busy_ff;
   assign cw        = ucode(step_ff);
   assign op_last   = (opcnt_ff == OPCNT_W'(OPS_PER_ALGO - 1));
   assign handoff   = busy_ff && cw.done && (!rsp_valid_ff || !rsp_stall);

   skc_ram #(
      .WIDTH (8),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (req_xfer && !req_mode && (req_table_address < 12'(TABLE_DEPTH))),
      .wr_addr (ADDR_W'(req_table_address)),
      .wr_data (req_table_byte),
      .rd_en   (busy_ff && cw.mem_rd),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      step_in = step_ff + STEP_W'(1);
      if (cw.jmp_more && !op_last) begin
         step_in = STEP_RD_CODE;
      end
      if (cw.done) begin
         step_in = step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= STEP_RD_CODE;
         opcnt_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (handoff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_xfer && req_mode) begin
            busy_ff  <= 1'b1;
            opcnt_ff <= '0;
            step_ff  <= (req_algo == 8'd0) ? STEP_DONE : STEP_RD_CODE;
         end else if (busy_ff) begin
            step_ff <= step_in;
            if (cw.exec) begin
               opcnt_ff <= opcnt_ff + OPCNT_W'(1);
            end
            if (handoff) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && req_mode) begin
         addr_ff  <= ADDR_W'(req_algo) * ADDR_W'(ENTRY_BYTES);
         value_ff <= (req_algo == 8'd0) ? ~req_seed : req_seed;
      end else if (busy_ff) begin
         if (cw.mem_rd) begin
            addr_ff <= addr_ff + ADDR_W'(1);
         end
         if (cw.ld_code) begin
            code_ff <= rd_data;
         end
         if (cw.ld_hh) begin
            hh_ff <= rd_data;
         end
         if (cw.exec) begin
            value_ff <= apply_op(value_ff, code_ff, hh_ff, rd_data);
         end
      end
      if (handoff) begin
         rsp_key_ff <= value_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_key   = rsp_key_ff;

endmodule

### rtl/skc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module skc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
